/* design/rlsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run-length screen decoder package
// Shared types and codes for the front, the queue and the back.
// ----------------------------------------------------------------------------
package rlsd_pkg;

  // Byte parser state
  typedef enum logic [1:0] {
    MODE_CMD    = 2'd0,
    MODE_RUNVAL = 2'd1,
    MODE_LIT    = 2'd2,
    MODE_DRAIN  = 2'd3
  } rlsd_mode_e;

  // Result status codes
  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Command byte fields
  localparam logic [7:0] CMD_RUN_BIT = 8'h80;
  localparam logic [7:0] CMD_CNT_MSK = 8'h7F;

  // Work for the back end: an optional data result, then an optional error
  typedef struct packed {
    logic       data_vld;
    logic [7:0] value;
    logic [7:0] rpt;
    logic       done;
    logic       err;
  } rlsd_entry_t;

endpackage
`default_nettype wire

/* design/run_length_screen_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run-length screen decoder
// PackBits-style decoder that turns a compressed frame into run results.
// ----------------------------------------------------------------------------
// One compressed byte is taken per cycle whenever the four-entry work queue
// between the parser and the result stage has room. Command bytes give no
// result unless they overrun the frame or end it, which gives an error
// result; each data byte gives one run or literal result, and an early frame
// end adds an error result after it. The result stage sends one result per
// cycle from its output register while results are popped; the queue
// absorbs the extra result of a byte with two. Results pass through the
// work queue and then the output register before they reach the outputs.
module run_length_screen_decoder #(
  parameter int FRAME_BYTES = 480
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] code_byte_i,
  input  wire logic       frame_end_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      value_o,
  output logic [7:0]      repeat_res_o,
  output logic [1:0]      status_o
);
  import rlsd_pkg::*;

  logic        take;
  logic        post;
  rlsd_entry_t post_entry;
  logic        q_nempty;
  logic        q_rd;
  rlsd_entry_t q_data;

  // Transfer a byte when the queue can take its work
  assign take = push && !full;

  rlsd_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .code_byte_i (code_byte_i),
    .frame_end_i (frame_end_i),
    .post_o      (post),
    .entry_o     (post_entry)
  );

  rlsd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (post),
    .wr_data_i (post_entry),
    .full_o    (full),
    .rd_i      (q_rd),
    .nempty_o  (q_nempty),
    .rd_data_o (q_data)
  );

  rlsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_nempty_i   (q_nempty),
    .q_data_i     (q_data),
    .q_rd_o       (q_rd),
    .pop_i        (pop),
    .empty_o      (empty),
    .value_o      (value_o),
    .repeat_res_o (repeat_res_o),
    .status_o     (status_o)
  );

endmodule
`default_nettype wire

/* design/rlsd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run-length screen decoder front end
// Parses command bytes, tracks the output count and posts result work.
// ----------------------------------------------------------------------------
module rlsd_front #(
  parameter int FRAME_BYTES = 480
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire logic [7:0]         code_byte_i,
  input  wire logic               frame_end_i,
  output logic                    post_o,
  output rlsd_pkg::rlsd_entry_t   entry_o
);
  import rlsd_pkg::*;

  localparam int CntW = $clog2(FRAME_BYTES + 129);

  rlsd_mode_e      mode_q, mode_d;
  logic [7:0]      lit_left_q, lit_left_d;
  logic [7:0]      run_len_q, run_len_d;
  logic [CntW-1:0] produced_q, produced_d;

  logic [7:0]      cnt;
  logic [CntW-1:0] cmd_sum;
  logic [CntW-1:0] data_sum;
  logic            data_full;

  // Count carried by a command byte, 1..128
  assign cnt      = (code_byte_i & CMD_CNT_MSK) + 8'd1;
  assign cmd_sum  = produced_q + CntW'(cnt);
  assign data_sum = produced_q + ((mode_q == MODE_RUNVAL) ? CntW'(run_len_q) : CntW'(1));
  assign data_full = (data_sum >= CntW'(FRAME_BYTES));

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_CMD;
      lit_left_q <= '0;
      run_len_q  <= '0;
      produced_q <= '0;
    end else begin
      mode_q     <= mode_d;
      lit_left_q <= lit_left_d;
      run_len_q  <= run_len_d;
      produced_q <= produced_d;
    end
  end

  // Classify the byte and advance
  always_comb begin
    mode_d     = mode_q;
    lit_left_d = lit_left_q;
    run_len_d  = run_len_q;
    produced_d = produced_q;
    post_o     = 1'b0;
    entry_o    = '0;
    if (take_i) begin
      unique case (mode_q)
        MODE_CMD: begin
          if ((cmd_sum > CntW'(FRAME_BYTES)) || frame_end_i) begin
            post_o      = 1'b1;
            entry_o.err = 1'b1;
            mode_d      = MODE_DRAIN;
          end else if ((code_byte_i & CMD_RUN_BIT) != 8'd0) begin
            run_len_d = cnt;
            mode_d    = MODE_RUNVAL;
          end else begin
            lit_left_d = cnt;
            mode_d     = MODE_LIT;
          end
        end
        MODE_RUNVAL, MODE_LIT: begin
          post_o           = 1'b1;
          entry_o.data_vld = 1'b1;
          entry_o.value    = code_byte_i;
          produced_d       = data_sum;
          if (mode_q == MODE_RUNVAL) begin
            entry_o.rpt = run_len_q;
            run_len_d   = '0;
            mode_d      = MODE_CMD;
          end else begin
            entry_o.rpt = 8'd1;
            lit_left_d  = lit_left_q - 8'd1;
            if (lit_left_q == 8'd1) begin
              mode_d = MODE_CMD;
            end
          end
          if (data_full) begin
            entry_o.done = 1'b1;
            mode_d       = MODE_DRAIN;
          end else if (frame_end_i) begin
            entry_o.err = 1'b1;
          end
        end
        MODE_DRAIN: begin
        end
        default: begin
        end
      endcase
      // Return to idle on the frame's last byte
      if (frame_end_i) begin
        mode_d     = MODE_CMD;
        lit_left_d = '0;
        run_len_d  = '0;
        produced_d = '0;
      end
    end
  end

endmodule
`default_nettype wire

/* design/rlsd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run-length screen decoder work queue
// Four-entry queue of result work between the front and the back.
// ----------------------------------------------------------------------------
module rlsd_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  wr_i,
  input  wire rlsd_pkg::rlsd_entry_t wr_data_i,
  output logic                       full_o,
  input  wire logic                  rd_i,
  output logic                       nempty_o,
  output rlsd_pkg::rlsd_entry_t      rd_data_o
);
  import rlsd_pkg::*;

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  rlsd_entry_t       slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     count_q;
  logic              do_wr, do_rd;

  assign full_o    = (count_q == (PtrW + 1)'(Depth));
  assign nempty_o  = (count_q != '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && nempty_o;
  assign rd_data_o = slots_q[rd_ptr_q];

  // Store posted work
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + (PtrW + 1)'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - (PtrW + 1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* design/rlsd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run-length screen decoder back end
// Expands queued work into result transfers through an output register.
// ----------------------------------------------------------------------------
module rlsd_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_nempty_i,
  input  wire rlsd_pkg::rlsd_entry_t q_data_i,
  output logic                       q_rd_o,
  input  wire logic                  pop_i,
  output logic                       empty_o,
  output logic [7:0]                 value_o,
  output logic [7:0]                 repeat_res_o,
  output logic [1:0]                 status_o
);
  import rlsd_pkg::*;

  logic       out_vld_q, out_vld_d;
  logic       pend_err_q, pend_err_d;
  logic [7:0] value_q, value_d;
  logic [7:0] rpt_q, rpt_d;
  logic [1:0] status_q, status_d;
  logic       slot_free;

  assign slot_free    = !out_vld_q || pop_i;
  assign empty_o      = !out_vld_q;
  assign value_o      = value_q;
  assign repeat_res_o = rpt_q;
  assign status_o     = status_q;

  // Load the next result when the output slot frees up
  always_comb begin
    out_vld_d  = out_vld_q;
    pend_err_d = pend_err_q;
    value_d    = value_q;
    rpt_d      = rpt_q;
    status_d   = status_q;
    q_rd_o     = 1'b0;
    if (slot_free) begin
      out_vld_d = 1'b0;
      if (pend_err_q) begin
        out_vld_d  = 1'b1;
        pend_err_d = 1'b0;
        value_d    = '0;
        rpt_d      = '0;
        status_d   = ST_ERR;
      end else if (q_nempty_i) begin
        q_rd_o    = 1'b1;
        out_vld_d = 1'b1;
        if (q_data_i.data_vld) begin
          value_d    = q_data_i.value;
          rpt_d      = q_data_i.rpt;
          status_d   = q_data_i.done ? ST_DONE : ST_MORE;
          pend_err_d = q_data_i.err;
        end else begin
          value_d  = '0;
          rpt_d    = '0;
          status_d = ST_ERR;
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      pend_err_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      pend_err_q <= pend_err_d;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    rpt_q    <= rpt_d;
    status_q <= status_d;
  end

endmodule
`default_nettype wire
